// ----- rtl/core/wps_pkg.sv -----
`default_nettype none
package wps_pkg;

    localparam int BITS_PER_PIXEL_DEFAULT = 24;
    localparam int COLOR_W = 24;
    localparam int SHORT_W = 16;
    localparam int DUR_W   = 20;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = DUR_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LATCH     = 3'd4;

    // reset timings in 5 ns ticks
    localparam logic [SHORT_W-1:0] ONE_HIGH_RST  = 16'd140;
    localparam logic [SHORT_W-1:0] ONE_LOW_RST   = 16'd160;
    localparam logic [SHORT_W-1:0] ZERO_HIGH_RST = 16'd70;
    localparam logic [SHORT_W-1:0] ZERO_LOW_RST  = 16'd120;
    localparam logic [DUR_W-1:0]   LATCH_RST     = 20'd12000;

    typedef struct packed {
        logic [COLOR_W-1:0] pixel_color;
        logic               frame_end;
    } t_pixel_in;

    typedef struct packed {
        logic             pin_level;
        logic [DUR_W-1:0] duration_ticks;
        logic             run_last;
    } t_seg_out;

    typedef struct packed {
        logic [SHORT_W-1:0] one_high;
        logic [SHORT_W-1:0] one_low;
        logic [SHORT_W-1:0] zero_high;
        logic [SHORT_W-1:0] zero_low;
        logic [DUR_W-1:0]   latch;
    } t_timing;

endpackage
`default_nettype wire

// ----- rtl/core/ws2812_pixel_serializer.sv -----
`default_nettype none
// Serializes one colour word per input beat into pin-level segments for a single-wire
// self-clocked LED chain, most significant bit first: each bit gives a high segment then
// a low segment, with one-bit and zero-bit durations from the timing registers, and a
// pixel marked frame_end adds a low latch segment; run_last marks a pixel's final segment.
// A pixel gives 2*BITS_PER_PIXEL segments, plus one with frame_end, and the back-end
// sequencer issues one segment per cycle through its output register unless i_out_ready
// stalls it; pixels wait in a two-entry queue, and an idle load step that issues no
// segment comes only when the queue has run dry. Timing registers written
// as zero are used as one tick. Write them only while the block is idle.
module ws2812_pixel_serializer #(
    parameter int BITS_PER_PIXEL = wps_pkg::BITS_PER_PIXEL_DEFAULT
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire wps_pkg::t_pixel_in                i_in_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output wps_pkg::t_seg_out                      o_out_data,
    input  wire logic                              i_cfg_we,
    input  wire logic [wps_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [wps_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int EXT_W = (BITS_PER_PIXEL > wps_pkg::COLOR_W) ? BITS_PER_PIXEL
                                                                : wps_pkg::COLOR_W;
    localparam int WORD_W = BITS_PER_PIXEL + 1;

    wps_pkg::t_timing            r_timing;
    logic [wps_pkg::SHORT_W-1:0] cfg_short;
    logic [wps_pkg::DUR_W-1:0]   cfg_long;
    logic [EXT_W-1:0]            color_ext;
    logic [WORD_W-1:0]           q_wr_data;
    logic [WORD_W-1:0]           q_rd_data;
    logic                        q_ready;
    logic                        q_valid;
    logic                        q_pop;

    // a zero duration is sent as one tick
    always_comb begin
        cfg_short = i_cfg_data[wps_pkg::SHORT_W-1:0];
        if (cfg_short == '0) begin
            cfg_short = wps_pkg::SHORT_W'(1);
        end
        cfg_long = i_cfg_data;
        if (cfg_long == '0) begin
            cfg_long = wps_pkg::DUR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timing.one_high  <= wps_pkg::ONE_HIGH_RST;
            r_timing.one_low   <= wps_pkg::ONE_LOW_RST;
            r_timing.zero_high <= wps_pkg::ZERO_HIGH_RST;
            r_timing.zero_low  <= wps_pkg::ZERO_LOW_RST;
            r_timing.latch     <= wps_pkg::LATCH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                wps_pkg::REG_ONE_HIGH:  r_timing.one_high  <= cfg_short;
                wps_pkg::REG_ONE_LOW:   r_timing.one_low   <= cfg_short;
                wps_pkg::REG_ZERO_HIGH: r_timing.zero_high <= cfg_short;
                wps_pkg::REG_ZERO_LOW:  r_timing.zero_low  <= cfg_short;
                wps_pkg::REG_LATCH:     r_timing.latch     <= cfg_long;
                default: begin
                end
            endcase
        end
    end

    // front: fit the colour word to the pixel length, leading bits above it are zero
    assign color_ext = EXT_W'(i_in_data.pixel_color);
    assign q_wr_data = {color_ext[BITS_PER_PIXEL-1:0], i_in_data.frame_end};

    wps_queue #(
        .WIDTH (WORD_W)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_in_valid),
        .o_wr_ready (q_ready),
        .i_wr_data  (q_wr_data),
        .o_rd_valid (q_valid),
        .i_rd_pop   (q_pop),
        .o_rd_data  (q_rd_data)
    );

    wps_back #(
        .BITS_PER_PIXEL (BITS_PER_PIXEL)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_q_pop     (q_pop),
        .i_q_bits    (q_rd_data[WORD_W-1:1]),
        .i_q_latch   (q_rd_data[0]),
        .i_timing    (r_timing),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    assign o_in_ready = q_ready;

`ifndef SYNTH
    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !q_ready |-> q_valid)
        else $error("queue full but empty");

    a_pop_only_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

    a_high_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.pin_level |-> !o_out_data.run_last)
        else $error("high segment marked as last of run");

    a_dur_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.duration_ticks != '0))
        else $error("zero-length segment");
`endif

endmodule
`default_nettype wire

// ----- rtl/core/wps_queue.sv -----
`default_nettype none
module wps_queue #(
    parameter int WIDTH = 25
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr_valid,
    output logic                  o_wr_ready,
    input  wire logic [WIDTH-1:0] i_wr_data,
    output logic                  o_rd_valid,
    input  wire logic             i_rd_pop,
    output logic [WIDTH-1:0]      o_rd_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             push;
    logic             pop;

    assign o_wr_ready = (r_count != 2'd2);
    assign o_rd_valid = (r_count != 2'd0);
    assign o_rd_data  = r_mem[r_rd_ptr];
    assign push = i_wr_valid && o_wr_ready;
    assign pop  = i_rd_pop && o_rd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/wps_back.sv -----
`default_nettype none
module wps_back #(
    parameter int BITS_PER_PIXEL = wps_pkg::BITS_PER_PIXEL_DEFAULT
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_q_valid,
    output logic                           o_q_pop,
    input  wire logic [BITS_PER_PIXEL-1:0] i_q_bits,
    input  wire logic                      i_q_latch,
    input  wire wps_pkg::t_timing          i_timing,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output wps_pkg::t_seg_out              o_out_data
);

    localparam int CNT_W = $clog2(BITS_PER_PIXEL);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_HIGH  = 2'd1;
    localparam logic [1:0] S_LOW   = 2'd2;
    localparam logic [1:0] S_LATCH = 2'd3;

    logic [1:0]                r_state, n_state;
    logic [BITS_PER_PIXEL-1:0] r_bits, n_bits;
    logic [CNT_W-1:0]          r_cnt, n_cnt;
    logic                      r_latch, n_latch;
    logic                      r_out_valid;
    wps_pkg::t_seg_out         r_out;
    wps_pkg::t_seg_out         seg;
    logic                      adv;
    logic                      emit;
    logic                      load;
    logic                      cur_bit;

    assign adv     = !r_out_valid || i_out_ready;
    assign cur_bit = r_bits[BITS_PER_PIXEL-1];

    always_comb begin
        n_state = r_state;
        n_bits  = r_bits;
        n_cnt   = r_cnt;
        n_latch = r_latch;
        emit    = 1'b0;
        load    = 1'b0;
        seg     = '0;
        case (r_state)
            S_IDLE: begin
                load = i_q_valid;
            end
            S_HIGH: begin
                if (adv) begin
                    emit = 1'b1;
                    seg.pin_level = 1'b1;
                    seg.duration_ticks = cur_bit ? wps_pkg::DUR_W'(i_timing.one_high)
                                                 : wps_pkg::DUR_W'(i_timing.zero_high);
                    n_state = S_LOW;
                end
            end
            S_LOW: begin
                if (adv) begin
                    emit = 1'b1;
                    seg.duration_ticks = cur_bit ? wps_pkg::DUR_W'(i_timing.one_low)
                                                 : wps_pkg::DUR_W'(i_timing.zero_low);
                    if (r_cnt != '0) begin
                        n_bits  = {r_bits[BITS_PER_PIXEL-2:0], 1'b0};
                        n_cnt   = r_cnt - CNT_W'(1);
                        n_state = S_HIGH;
                    end else if (r_latch) begin
                        n_state = S_LATCH;
                    end else begin
                        seg.run_last = 1'b1;
                        load    = i_q_valid;
                        n_state = S_IDLE;
                    end
                end
            end
            S_LATCH: begin
                if (adv) begin
                    emit = 1'b1;
                    seg.duration_ticks = i_timing.latch;
                    seg.run_last = 1'b1;
                    load    = i_q_valid;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // a queued next pixel is loaded with the last segment, so it follows without a gap
        if (load) begin
            n_bits  = i_q_bits;
            n_latch = i_q_latch;
            n_cnt   = CNT_W'(BITS_PER_PIXEL - 1);
            n_state = S_HIGH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (adv) begin
                r_out_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bits  <= n_bits;
        r_cnt   <= n_cnt;
        r_latch <= n_latch;
        if (adv && emit) begin
            r_out <= seg;
        end
    end

    assign o_q_pop     = load;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire
